// ===== hw/rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and codes of the power-of-two block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned OwnerW = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 6;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ExpW   = 6;
  localparam int unsigned AddrW  = 35;
  localparam int unsigned InTdataW  = 112;
  localparam int unsigned OutTdataW = 80;

  localparam logic [CmdW-1:0] CmdAlloc     = 2'd0;
  localparam logic [CmdW-1:0] CmdFreeAddr  = 2'd1;
  localparam logic [CmdW-1:0] CmdFreeOwner = 2'd2;

  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StTooLarge = 3'd1;
  localparam logic [StatW-1:0] StNoSpace  = 3'd2;
  localparam logic [StatW-1:0] StNoRecord = 3'd3;
  localparam logic [StatW-1:0] StNotFound = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgRegionBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegionSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeLimit  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAllocBase  = 2'd3;

  localparam logic [DataW-1:0] RegionBaseRst = 32'h0010_0000;

  localparam int unsigned RecW = 2 * DataW + DataW + OwnerW;

endpackage

// ===== hw/rtl/pba_ram.sv =====
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pow2_block_allocator.sv =====
// ----------------------------------------------------------------------------
// pow2_block_allocator
// First-fit power-of-two block allocator over a table of allocation records.
// ----------------------------------------------------------------------------
//  channel   dir  beat content
//  s_axis    in   command, request_size, owner_id, virt_addr, free_address
//  m_axis    out  status, block_address, granted_size, freed_count
//  cfg       in   register write: region_base, region_size, size_limit, alloc_base
//
//  One item at a time. Allocate: size rounding, then per candidate slot one
//  pass over the record RAM (one record read per cycle), plus the control
//  states S_CHECK, S_WRITE and S_OUT. Frees take one pass.
//  Reset clears the record valid bits; no clearing pass.
//  A result waits in the output register; the next transfer is accepted then.
// ----------------------------------------------------------------------------
module pow2_block_allocator #(
  parameter int unsigned RECORD_COUNT = 64,
  parameter int unsigned PAGE_BYTES   = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // command, request_size, owner_id, virt_addr, free_address
  input  logic [pba_pkg::InTdataW-1:0]       s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status, block_address, granted_size, freed_count
  output logic [pba_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [pba_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pba_pkg::DataW-1:0]          cfg_data_i
);
  import pba_pkg::*;

  localparam int unsigned IW = $clog2(RECORD_COUNT);
  localparam int unsigned PageLog = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_CHECK, S_WALK, S_WRITE, S_OUT
  } state_e;

  state_e state_q;
  logic [DataW-1:0] rbase_q, rsize_q, slimit_q, abase_q;
  logic [CmdW-1:0] cmd_q;
  logic [DataW-1:0] req_q, virt_q, fa_q;
  logic [OwnerW-1:0] own_q;
  logic [ExpW-1:0] exp_q;
  logic [AddrW-1:0] addr_q, nxt_q;
  logic hit_q, found_q, free_vld_q, cv_q;
  logic [IW-1:0] free_q, ci_q;
  logic [IW:0] idx_q;
  logic [CountW-1:0] cnt_q;
  logic [RECORD_COUNT-1:0] used_q;
  logic [StatW-1:0] rst_q;
  logic [DataW-1:0] rba_q, rgs_q;
  logic [CountW-1:0] rfc_q;
  logic ov_q;
  logic [StatW-1:0] ost_q;
  logic [DataW-1:0] oba_q, ogs_q;
  logic [CountW-1:0] ofc_q;

  logic ram_we;
  logic [RecW-1:0] ram_wdata, ram_rdata;
  logic [DataW-1:0] rd_addr, rd_size;
  logic [OwnerW-1:0] rd_own;
  logic [AddrW-1:0] size35, rec_end, cand, nxt_d, limit35;
  logic [32:0] size33;
  logic [ExpW-1:0] exp_pg;
  logic ovl, in_acc, last_cmp, rec_used;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_addr = ram_rdata[DataW-1:0];
  assign rd_size = ram_rdata[2*DataW-1:DataW];
  assign rd_own  = ram_rdata[2*DataW+OwnerW-1:2*DataW];
  assign ram_we  = (state_q == S_WRITE);
  assign ram_wdata = {((virt_q != '0) ? virt_q : addr_q[DataW-1:0]), own_q,
                      size35[DataW-1:0], addr_q[DataW-1:0]};

  pba_ram #(.WIDTH(RecW), .DEPTH(RECORD_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign size33  = 33'(1) << exp_q;
  assign exp_pg  = (exp_q < ExpW'(PageLog)) ? ExpW'(PageLog) : exp_q;
  assign size35  = AddrW'(1) << exp_q;
  assign limit35 = AddrW'(rbase_q) + AddrW'(rsize_q);
  assign rec_end = AddrW'(rd_addr) + AddrW'(rd_size);
  assign cand    = AddrW'(abase_q)
                 + ((rec_end - AddrW'(abase_q) + size35 - AddrW'(1)) & ~(size35 - AddrW'(1)));
  assign rec_used = used_q[ci_q];
  assign ovl = cv_q && rec_used && (AddrW'(rd_addr) < addr_q + size35) && (addr_q < rec_end);
  assign nxt_d = (ovl && cand > nxt_q) ? cand : nxt_q;
  assign last_cmp = cv_q && (ci_q == IW'(RECORD_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rbase_q <= RegionBaseRst;
      rsize_q <= '0;
      slimit_q <= '0;
      abase_q <= '0;
      used_q <= '0;
      ov_q <= 1'b0;
      cv_q <= 1'b0;
    end else begin
      if (ov_q && m_axis_tready_i && state_q != S_OUT) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRegionBase: rbase_q  <= cfg_data_i;
          CfgRegionSize: rsize_q  <= cfg_data_i;
          CfgSizeLimit:  slimit_q <= cfg_data_i;
          CfgAllocBase:  abase_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q  <= s_axis_tdata_i[1:0];
            req_q  <= s_axis_tdata_i[33:2];
            own_q  <= s_axis_tdata_i[41:34];
            virt_q <= s_axis_tdata_i[73:42];
            fa_q   <= s_axis_tdata_i[105:74];
            exp_q  <= '0;
            idx_q  <= (IW+1)'(1);
            cv_q   <= 1'b0;
            found_q <= 1'b0;
            cnt_q  <= '0;
            rba_q  <= '0;
            rgs_q  <= '0;
            rfc_q  <= '0;
            unique case (s_axis_tdata_i[1:0]) inside
              CmdAlloc: state_q <= S_ROUND;
              CmdFreeAddr, CmdFreeOwner: state_q <= S_WALK;
              default: begin
                rst_q <= StNotFound;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_ROUND: begin
          if (req_q == '0) begin
            exp_q <= ExpW'(PageLog);
            addr_q <= AddrW'(abase_q) + (AddrW'(1) << PageLog);
            state_q <= S_CHECK;
          end else if (size33 >= {1'b0, req_q}) begin
            if (size33 > {1'b0, slimit_q}) begin
              rst_q <= StTooLarge;
              state_q <= S_OUT;
            end else begin
              exp_q <= exp_pg;
              addr_q <= AddrW'(abase_q) + (AddrW'(1) << exp_pg);
              state_q <= S_CHECK;
            end
          end else begin
            exp_q <= exp_q + ExpW'(1);
          end
        end
        S_CHECK: begin
          if (addr_q + size35 > limit35) begin
            rst_q <= StNoSpace;
            rgs_q <= size35[DataW-1:0];
            state_q <= S_OUT;
          end else begin
            idx_q <= (IW+1)'(1);
            cv_q <= 1'b0;
            hit_q <= 1'b0;
            free_vld_q <= 1'b0;
            nxt_q <= addr_q + size35;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          cv_q <= (idx_q < (IW+1)'(RECORD_COUNT));
          ci_q <= idx_q[IW-1:0];
          if (idx_q < (IW+1)'(RECORD_COUNT)) begin
            idx_q <= idx_q + (IW+1)'(1);
          end
          if (cmd_q == CmdAlloc) begin
            nxt_q <= nxt_d;
            if (ovl) begin
              hit_q <= 1'b1;
            end
            if (cv_q && !rec_used && !free_vld_q) begin
              free_vld_q <= 1'b1;
              free_q <= ci_q;
            end
            if (last_cmp) begin
              cv_q <= 1'b0;
              if (hit_q || ovl) begin
                addr_q <= nxt_d;
                state_q <= S_CHECK;
              end else if (free_vld_q || !rec_used) begin
                state_q <= S_WRITE;
              end else begin
                rst_q <= StNoRecord;
                rgs_q <= size35[DataW-1:0];
                state_q <= S_OUT;
              end
            end
          end else begin
            if (cmd_q == CmdFreeAddr) begin
              if (cv_q && rec_used && !found_q && rd_addr == fa_q) begin
                used_q[ci_q] <= 1'b0;
                found_q <= 1'b1;
              end
            end else if (cv_q && rec_used && rd_own == own_q) begin
              used_q[ci_q] <= 1'b0;
              if (cnt_q != '1) begin
                cnt_q <= cnt_q + CountW'(1);
              end
            end
            if (last_cmp) begin
              cv_q <= 1'b0;
              state_q <= S_OUT;
              if (cmd_q == CmdFreeAddr) begin
                if (found_q || (rec_used && rd_addr == fa_q)) begin
                  rst_q <= StOk;
                  rfc_q <= CountW'(1);
                end else begin
                  rst_q <= StNotFound;
                end
              end else begin
                rst_q <= StOk;
                rfc_q <= (rec_used && rd_own == own_q && cnt_q != '1)
                         ? cnt_q + CountW'(1) : cnt_q;
              end
            end
          end
        end
        S_WRITE: begin
          used_q[free_q] <= 1'b1;
          rst_q <= StOk;
          rba_q <= addr_q[DataW-1:0];
          rgs_q <= size35[DataW-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!ov_q || m_axis_tready_i) begin
            ov_q <= 1'b1;
            ost_q <= rst_q;
            oba_q <= rba_q;
            ogs_q <= rgs_q;
            ofc_q <= rfc_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {7'd0, ofc_q, ogs_q, oba_q, ost_q};

endmodule
